>>> src/fsra_pkg.sv
// Shared types, codes and widths of the fence-reclaimed slot allocator.
`timescale 1ns / 1ps

package fsra_pkg;

    localparam int POOL_SLOTS_DEF = 16;

    localparam int FUNC_W      = 2;
    localparam int SLOT_W      = 4;
    localparam int FENCE_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUBMIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RECLAIM = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FENCE_ZERO    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_RECORDING = 2'd3;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_SUBMIT,
        OP_RECLAIM,
        OP_NOP
    } op_kind_t;

    // One classified item as it waits between the front and the back end.
    typedef struct packed {
        op_kind_t            kind;
        logic [SLOT_W-1:0]   slot;
        logic                fence_zero;
        logic [FENCE_W-1:0]  operand;
    } op_entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_RESP
    } back_state_t;

endpackage

>>> src/fsra_front.sv
// Front end: accepts input items, decodes the function and queues one operation per item.
`timescale 1ns / 1ps

module fsra_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // func[1:0], slot[5:2], fence_value[69:6], completed_fence[133:70], zero pad
    input  logic [fsra_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                        q_full,
    output logic                        q_push,
    output fsra_pkg::op_entry_t         q_entry
);

    logic [fsra_pkg::FUNC_W-1:0]  func;
    logic [fsra_pkg::SLOT_W-1:0]  slot;
    logic [fsra_pkg::FENCE_W-1:0] fence_value;
    logic [fsra_pkg::FENCE_W-1:0] completed_fence;

    assign func            = s_tdata[1:0];
    assign slot            = s_tdata[5:2];
    assign fence_value     = s_tdata[69:6];
    assign completed_fence = s_tdata[133:70];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        case (func)
            fsra_pkg::FUNC_ALLOC:   q_entry.kind = fsra_pkg::OP_ALLOC;
            fsra_pkg::FUNC_SUBMIT:  q_entry.kind = fsra_pkg::OP_SUBMIT;
            fsra_pkg::FUNC_RECLAIM: q_entry.kind = fsra_pkg::OP_RECLAIM;
            default:                q_entry.kind = fsra_pkg::OP_NOP;
        endcase
        q_entry.slot       = slot;
        q_entry.fence_zero = (fence_value == '0);
        // Submit needs only its own fence; allocate and reclaim need only the completed fence.
        q_entry.operand    = (func == fsra_pkg::FUNC_SUBMIT) ? fence_value : completed_fence;
    end

endmodule

>>> src/fsra_queue.sv
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module fsra_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fsra_pkg::op_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output fsra_pkg::op_entry_t pop_entry,
    output logic                empty
);

    fsra_pkg::op_entry_t                 entry_reg [fsra_pkg::QUEUE_DEPTH];
    logic [fsra_pkg::QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [fsra_pkg::QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [fsra_pkg::QUEUE_CW-1:0]       count_reg, count_next;
    logic                                do_push, do_pop;

    assign full      = (count_reg == fsra_pkg::QUEUE_CW'(fsra_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> src/fsra_back.sv
// Back end: slot state, fence memory scan, lowest-free pick and the result register.
`timescale 1ns / 1ps

module fsra_back #(
    parameter int POOL_SLOTS = fsra_pkg::POOL_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  fsra_pkg::op_entry_t            q_entry,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fsra_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int EXT_W  = ((IDX_W > fsra_pkg::SLOT_W) ? IDX_W : fsra_pkg::SLOT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

    fsra_pkg::back_state_t state_reg, state_next;
    fsra_pkg::op_entry_t   op_reg;

    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic                          cmp_vld_reg;
    logic [IDX_W-1:0]              cmp_idx_reg;
    logic [fsra_pkg::FENCE_W-1:0]  rd_data_reg;
    logic [fsra_pkg::FENCE_W-1:0]  fence_mem_reg [POOL_SLOTS];
    logic [POOL_SLOTS-1:0]         free_mask_reg, free_mask_next;
    logic [POOL_SLOTS-1:0]         sub_mask_reg, sub_mask_next;
    logic                          m_tvalid_reg;
    logic [fsra_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic                          out_free;
    logic                          resp_fire;
    logic                          reclaim_hit;
    logic [POOL_SLOTS-1:0]         cmp_onehot;
    logic [EXT_W-1:0]              slot_ext;
    logic [IDX_W-1:0]              slot_addr;
    logic                          slot_in_pool;
    logic [POOL_SLOTS-1:0]         slot_onehot;
    logic                          slot_recording;
    logic [POOL_SLOTS-1:0]         lowest_free;
    logic [EXT_W-1:0]              pick_idx;
    logic                          submit_ok;
    logic                          grant_ok;
    logic [fsra_pkg::STATUS_W-1:0] status;
    logic [fsra_pkg::SLOT_W-1:0]   granted_slot;
    logic                          any_free;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fsra_pkg::B_IDLE: begin
                if (!q_empty) begin
                    if (q_entry.kind == fsra_pkg::OP_ALLOC ||
                        q_entry.kind == fsra_pkg::OP_RECLAIM) begin
                        state_next = fsra_pkg::B_SCAN;
                    end else begin
                        state_next = fsra_pkg::B_RESP;
                    end
                end
            end
            fsra_pkg::B_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = fsra_pkg::B_DRAIN;
                end
            end
            fsra_pkg::B_DRAIN: state_next = fsra_pkg::B_RESP;
            fsra_pkg::B_RESP: begin
                if (out_free) begin
                    state_next = fsra_pkg::B_IDLE;
                end
            end
            default: state_next = fsra_pkg::B_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        q_pop     = 1'b0;
        resp_fire = 1'b0;
        idx_next  = idx_reg;
        case (state_reg)
            fsra_pkg::B_IDLE: begin
                q_pop    = !q_empty;
                idx_next = '0;
            end
            fsra_pkg::B_SCAN: idx_next = idx_reg + 1'b1;
            fsra_pkg::B_RESP: resp_fire = out_free;
            default: ;
        endcase
    end

    // The compare works on the registered read data and index, in the cycle after the fence memory read.
    assign cmp_onehot  = POOL_SLOTS'(1) << cmp_idx_reg;
    assign reclaim_hit = cmp_vld_reg && sub_mask_reg[cmp_idx_reg] &&
                         (rd_data_reg <= op_reg.operand);

    assign slot_ext       = EXT_W'(op_reg.slot);
    assign slot_addr      = slot_ext[IDX_W-1:0];
    assign slot_in_pool   = (slot_ext < EXT_W'(POOL_SLOTS));
    assign slot_onehot    = POOL_SLOTS'(1) << slot_addr;
    assign slot_recording = slot_in_pool && !free_mask_reg[slot_addr] && !sub_mask_reg[slot_addr];

    // Isolate the lowest set bit, then encode it.
    assign lowest_free = free_mask_reg & (~free_mask_reg + 1'b1);

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            if (lowest_free[i]) begin
                pick_idx = pick_idx | EXT_W'(i);
            end
        end
    end

    always_comb begin
        status       = fsra_pkg::ST_OK;
        granted_slot = '0;
        submit_ok    = 1'b0;
        grant_ok     = 1'b0;
        any_free     = |free_mask_reg;
        case (op_reg.kind)
            fsra_pkg::OP_ALLOC: begin
                if (free_mask_reg == '0) begin
                    status = fsra_pkg::ST_NO_FREE;
                end else begin
                    grant_ok     = 1'b1;
                    granted_slot = pick_idx[fsra_pkg::SLOT_W-1:0];
                    any_free     = |(free_mask_reg & ~lowest_free);
                end
            end
            fsra_pkg::OP_SUBMIT: begin
                if (op_reg.fence_zero) begin
                    status = fsra_pkg::ST_FENCE_ZERO;
                end else if (!slot_recording) begin
                    status = fsra_pkg::ST_NOT_RECORDING;
                end else begin
                    submit_ok = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        free_mask_next = free_mask_reg;
        sub_mask_next  = sub_mask_reg;
        if (reclaim_hit) begin
            free_mask_next = free_mask_reg | cmp_onehot;
            sub_mask_next  = sub_mask_reg & ~cmp_onehot;
        end else if (resp_fire && grant_ok) begin
            free_mask_next = free_mask_reg & ~lowest_free;
        end else if (resp_fire && submit_ok) begin
            sub_mask_next = sub_mask_reg | slot_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fsra_pkg::B_IDLE;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            free_mask_reg <= '1;
            sub_mask_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_vld_reg   <= (state_reg == fsra_pkg::B_SCAN);
            free_mask_reg <= free_mask_next;
            sub_mask_reg  <= sub_mask_next;
            if (resp_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= idx_reg;
        if (q_pop) begin
            op_reg <= q_entry;
        end
        if (resp_fire) begin
            m_tdata_reg <= {1'b0, any_free, granted_slot, status};
        end
    end

    // Fence memory: one read port for the scan, one write port for submit.
    always_ff @(posedge aclk) begin
        rd_data_reg <= fence_mem_reg[idx_reg];
        if (resp_fire && submit_ok) begin
            fence_mem_reg[slot_addr] <= op_reg.operand;
        end
    end

`ifndef SYNTH
    a_masks_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_mask_reg & sub_mask_reg) == '0)
        else $error("slot both free and submitted");

    a_scan_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fsra_pkg::B_SCAN && idx_reg == LAST_IDX) |=>
        (state_reg == fsra_pkg::B_DRAIN && cmp_vld_reg))
        else $error("scan did not end in drain");

    a_cmp_follows_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (state_reg == fsra_pkg::B_SCAN || state_reg == fsra_pkg::B_DRAIN))
        else $error("compare outside of a scan");

    a_no_free_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (resp_fire && op_reg.kind == fsra_pkg::OP_ALLOC && !grant_ok) |=>
        (m_tdata_reg[1:0] == fsra_pkg::ST_NO_FREE && !m_tdata_reg[6]))
        else $error("no-free result reports a free slot");
`endif

endmodule

>>> src/fence_reclaimed_slot_allocator.sv
// Top level of the fence-reclaimed slot allocator.
`timescale 1ns / 1ps

// A pool of POOL_SLOTS slots, each free, recording or submitted with a 64-bit fence.
// Every item gives one result. Items enter a two-entry queue, so until it is full
// the input keeps taking items while the back end works and while a result waits
// on m_tready. Allocate and reclaim items go through the back-end states in order:
// idle takes the item from the queue; the fence memory has one read port, so the
// reclaim scan reads and compares one slot fence per cycle; drain finishes the last
// compare; then respond picks the lowest free slot and loads the result once the
// output is free. Submit and unused function codes go from idle straight to respond.
// No clearing pass is needed after reset; the fence memory is read in every scan,
// but only the fences of submitted slots take part in a reclaim.
module fence_reclaimed_slot_allocator #(
    parameter int POOL_SLOTS = fsra_pkg::POOL_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func[1:0], slot[5:2], fence_value[69:6], completed_fence[133:70], zero pad
    input  logic [fsra_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], granted_slot[5:2], any_free[6], zero pad
    output logic [fsra_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                q_full, q_empty, q_push, q_pop;
    fsra_pkg::op_entry_t push_entry, pop_entry;

    fsra_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    fsra_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    fsra_back #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
